// File: rtl/at_command_link_handshake_core_assert.svh
// assertion macros for the link handshake core
`ifndef AT_COMMAND_LINK_HANDSHAKE_CORE_ASSERT_SVH
`define AT_COMMAND_LINK_HANDSHAKE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ATCL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ATCL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ATCL_ASSERT(label, clk, rst_n, prop, msg)
`define ATCL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/atcl_pkg.sv
package atcl_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int MAC_OFFSET     = 5;
  localparam int MAC_DIGITS     = 12;
  localparam int MAC_W          = 4 * MAC_DIGITS;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_GAP_MS = 1'b0;
  localparam logic [15:0] GAP_MS_RESET = 16'd50;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_O    = 8'h4f;
  localparam logic [7:0] CH_K    = 8'h4b;
  localparam logic [7:0] CH_M    = 8'h4d;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TX_NONE   = 2'd0,
    TX_NAME   = 2'd1,
    TX_MAC    = 2'd2,
    TX_HOSTEN = 2'd3
  } tx_e;

  typedef struct packed {
    logic       store;
    logic       clear;
    logic [7:0] data;
  } line_ctrl_t;

  typedef struct packed {
    logic             ok_seen;
    logic             mac_seen;
    logic [MAC_W-1:0] shadow;
  } line_stat_t;

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = 4'(c - 8'h57);
    end
    return n;
  endfunction

endpackage

// File: rtl/atcl_if.sv
interface atcl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface atcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tx_request;
  logic        fwd_valid;
  logic [7:0]  fwd_byte;
  logic        transparent_mode;
  logic        line_ready;
  logic        mac_valid;
  logic [47:0] mac_address;
  logic        handshake_done;

  modport source (
    output valid, tx_request, fwd_valid, fwd_byte, transparent_mode, line_ready,
           mac_valid, mac_address, handshake_done,
    input  ready
  );
  modport sink (
    input  valid, tx_request, fwd_valid, fwd_byte, transparent_mode, line_ready,
           mac_valid, mac_address, handshake_done,
    output ready
  );
endinterface

// File: rtl/atcl_line.sv
module atcl_line #(
  parameter int LineBytes = atcl_pkg::LINE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atcl_pkg::line_ctrl_t ctrl_i,
  output atcl_pkg::line_stat_t stat_o
);
  import atcl_pkg::*;

  localparam int CntW = $clog2(LineBytes);

  logic [CntW-1:0]  count_q, count_d;
  logic [15:0]      prev_q, prev_d;
  logic             ok_q, ok_d, mac_q, mac_d, nul_q, nul_d;
  logic [MAC_W-1:0] shadow_q, shadow_d;
  logic [CntW:0]    count_inc;
  logic [7:0]       last_b, before_b;

  assign last_b    = prev_q[7:0];
  assign before_b  = prev_q[15:8];
  assign count_inc = {1'b0, count_q} + (CntW+1)'(1);

  always_comb begin
    count_d  = count_q;
    prev_d   = prev_q;
    ok_d     = ok_q;
    mac_d    = mac_q;
    nul_d    = nul_q;
    shadow_d = shadow_q;
    if (ctrl_i.clear) begin
      count_d  = '0;
      prev_d   = '0;
      ok_d     = 1'b0;
      mac_d    = 1'b0;
      nul_d    = 1'b0;
      shadow_d = '0;
    end else if (ctrl_i.store) begin
      // matching stops at the first nul
      if (!nul_q) begin
        if (ctrl_i.data == CH_NUL) begin
          nul_d = 1'b1;
        end else begin
          if (last_b == CH_O && ctrl_i.data == CH_K) ok_d = 1'b1;
          if (before_b == CH_M && last_b == CH_A && ctrl_i.data == CH_C) mac_d = 1'b1;
        end
      end
      prev_d = {last_b, ctrl_i.data};
      for (int k = 0; k < MAC_DIGITS; k++) begin
        if (count_q == CntW'(MAC_OFFSET + k)) begin
          shadow_d[(MAC_DIGITS-1-k)*4 +: 4] = hex_nibble(ctrl_i.data);
        end
      end
      count_d = count_inc[CntW-1:0];
      // full line wraps back to empty
      if (count_inc >= (CntW+1)'(LineBytes)) begin
        count_d  = '0;
        prev_d   = '0;
        ok_d     = 1'b0;
        mac_d    = 1'b0;
        nul_d    = 1'b0;
        shadow_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prev_q   <= '0;
      ok_q     <= 1'b0;
      mac_q    <= 1'b0;
      nul_q    <= 1'b0;
      shadow_q <= '0;
    end else begin
      count_q  <= count_d;
      prev_q   <= prev_d;
      ok_q     <= ok_d;
      mac_q    <= mac_d;
      nul_q    <= nul_d;
      shadow_q <= shadow_d;
    end
  end

  assign stat_o.ok_seen  = ok_q;
  assign stat_o.mac_seen = mac_q;
  assign stat_o.shadow   = shadow_q;

endmodule

// File: rtl/at_command_link_handshake_core.sv
// Receive and handshake side of an AT-command radio link. Each input transfer carries a
// received byte, a millisecond tick, a poll or a start request; in command mode bytes are
// collected into a reply line that ends on a line feed or after gap_ms of silence, a poll
// matches the finished line for OK or MAC and steps the handshake (set name, query MAC,
// host enable, transparent), and in transparent mode bytes are forwarded. One item is
// accepted every clock cycle; its result appears in the output register on the next cycle.
// A new item is accepted in the same cycle that the waiting result is taken, so the input
// stalls only while the output register is full and not taken. gap_ms is written through
// the APB port at address 0.
`include "at_command_link_handshake_core_assert.svh"

module at_command_link_handshake_core #(
  parameter int LineBytes = atcl_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  atcl_in_if.sink                           in_i,
  atcl_out_if.source                        out_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [atcl_pkg::CFG_ADDR_W-1:0]   paddr_i,
  input  logic [atcl_pkg::CFG_DATA_W-1:0]   pwdata_i,
  output logic [atcl_pkg::CFG_DATA_W-1:0]   prdata_o,
  output logic                              pready_o
);
  import atcl_pkg::*;

  logic [15:0]      gap_ms_q;
  logic [31:0]      now_ms_q, now_ms_d;
  logic [31:0]      last_time_q, last_time_d;
  logic             busy_q, busy_d;
  logic             transparent_q, transparent_d;
  tx_e              pending_q, pending_d;
  logic             mac_valid_q, mac_valid_d;
  logic [MAC_W-1:0] mac_q, mac_d;

  logic             out_valid_q;
  tx_e              tx_q, tx_d;
  logic             fwd_valid_q, fwd_valid_d;
  logic [7:0]       fwd_byte_q, fwd_byte_d;
  logic             done_q, done_d;
  logic             line_ready_q;
  logic             trans_out_q;
  logic             mac_valid_out_q;
  logic [MAC_W-1:0] mac_out_q;

  logic       in_fire;
  logic       gap_hit;
  logic [31:0] gap_start;
  cmd_e       cmd;
  line_ctrl_t line_ctrl;
  line_stat_t line_stat;

  // configuration port
  assign pready_o = 1'b1;
  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == REG_GAP_MS) prdata_o = {{(CFG_DATA_W-16){1'b0}}, gap_ms_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ms_q <= GAP_MS_RESET;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_GAP_MS) begin
      gap_ms_q <= pwdata_i[15:0];
    end
  end

  // output register decouples the two sides
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.command);
  assign gap_start  = now_ms_q - {16'b0, gap_ms_q};
  assign gap_hit    = (gap_start > last_time_q) && (last_time_q != '0);

  always_comb begin
    now_ms_d      = now_ms_q;
    last_time_d   = last_time_q;
    busy_d        = busy_q;
    transparent_d = transparent_q;
    pending_d     = pending_q;
    mac_valid_d   = mac_valid_q;
    mac_d         = mac_q;
    tx_d          = TX_NONE;
    fwd_valid_d   = 1'b0;
    fwd_byte_d    = '0;
    done_d        = 1'b0;
    line_ctrl     = '0;
    line_ctrl.data = in_i.rx_byte;
    if (in_fire) begin
      case (cmd)
        CMD_BYTE: begin
          if (transparent_q) begin
            fwd_valid_d = 1'b1;
            fwd_byte_d  = in_i.rx_byte;
          end else if (!busy_q) begin
            if (in_i.rx_byte == CH_LF || gap_hit) begin
              busy_d      = 1'b1;
              last_time_d = '0;
            end else begin
              line_ctrl.store = 1'b1;
              last_time_d     = now_ms_q;
            end
          end
        end
        CMD_TICK: begin
          now_ms_d = now_ms_q + 32'd1;
        end
        CMD_POLL: begin
          if (!transparent_q && busy_q) begin
            line_ctrl.clear = 1'b1;
            last_time_d     = '0;
            busy_d          = 1'b0;
            case (pending_q)
              TX_MAC: begin
                if (line_stat.mac_seen) begin
                  mac_valid_d = 1'b1;
                  mac_d       = line_stat.shadow;
                  pending_d   = TX_HOSTEN;
                  tx_d        = TX_HOSTEN;
                end
              end
              TX_HOSTEN: begin
                if (line_stat.ok_seen) begin
                  transparent_d = 1'b1;
                  done_d        = 1'b1;
                end
              end
              TX_NAME: begin
                if (line_stat.ok_seen) begin
                  pending_d = TX_MAC;
                  tx_d      = TX_MAC;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_START: begin
          if (!transparent_q) begin
            line_ctrl.clear = 1'b1;
            pending_d       = TX_NAME;
            tx_d            = TX_NAME;
          end
        end
        default: ;
      endcase
    end
  end

  atcl_line #(
    .LineBytes(LineBytes)
  ) u_line (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(line_ctrl),
    .stat_o(line_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_ms_q      <= '0;
      last_time_q   <= '0;
      busy_q        <= 1'b0;
      transparent_q <= 1'b0;
      pending_q     <= TX_NONE;
      mac_valid_q   <= 1'b0;
      mac_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      now_ms_q      <= now_ms_d;
      last_time_q   <= last_time_d;
      busy_q        <= busy_d;
      transparent_q <= transparent_d;
      pending_q     <= pending_d;
      mac_valid_q   <= mac_valid_d;
      mac_q         <= mac_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tx_q            <= tx_d;
      fwd_valid_q     <= fwd_valid_d;
      fwd_byte_q      <= fwd_byte_d;
      done_q          <= done_d;
      line_ready_q    <= busy_d;
      trans_out_q     <= transparent_d;
      mac_valid_out_q <= mac_valid_d;
      mac_out_q       <= mac_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.tx_request       = tx_q;
  assign out_o.fwd_valid        = fwd_valid_q;
  assign out_o.fwd_byte         = fwd_byte_q;
  assign out_o.transparent_mode = trans_out_q;
  assign out_o.line_ready       = line_ready_q;
  assign out_o.mac_valid        = mac_valid_out_q;
  assign out_o.mac_address      = mac_out_q;
  assign out_o.handshake_done   = done_q;

  `ATCL_ASSERT_IMPL(a_done_in_transparent, clk_i, rst_ni, out_valid_q && done_q, trans_out_q, "handshake done without transparent mode")
  `ATCL_ASSERT_IMPL(a_fwd_in_transparent, clk_i, rst_ni, out_valid_q && fwd_valid_q, trans_out_q && !line_ready_q, "byte forwarded outside transparent mode")
  `ATCL_ASSERT_IMPL(a_hosten_has_mac, clk_i, rst_ni, out_valid_q && tx_q == TX_HOSTEN, mac_valid_out_q, "host enable requested before mac capture")
  `ATCL_ASSERT(a_transparent_sticky, clk_i, rst_ni, !$fell(transparent_q), "transparent mode left")

endmodule
